// ===== hdl/tsat_pkg.sv =====
package tsat_pkg;

	localparam int MAX_VARS_DEF    = 1024;
	localparam int MAX_CLAUSES_DEF = 2048;

	localparam int LIT_W     = 12;
	localparam int CFG_W     = 11;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 72;
	localparam int WORD_W    = 64;
	localparam int WIDX_W    = 4;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_ROOT,
		S_ROOTCHK,
		S_SCAN,
		S_EDGE,
		S_TGT,
		S_FIN,
		S_POPR,
		S_POPW,
		S_RET,
		S_RET2,
		S_ANEG,
		S_APOS,
		S_ACMP,
		S_ORD,
		S_OLD
	} state_t;

endpackage

// ===== hdl/tsat_clause_store.sv =====
module tsat_clause_store #(
	parameter int MAX_VARS    = tsat_pkg::MAX_VARS_DEF,
	parameter int MAX_CLAUSES = tsat_pkg::MAX_CLAUSES_DEF,
	localparam int NW  = $clog2(2 * MAX_VARS),
	localparam int VW  = $clog2(MAX_VARS + 1),
	localparam int CW  = $clog2(MAX_CLAUSES + 1),
	localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [VW-1:0]                       var_live,
	input  logic                                add_en,
	input  logic signed [tsat_pkg::LIT_W-1:0]   lit_a,
	input  logic signed [tsat_pkg::LIT_W-1:0]   lit_b,
	input  logic                                clear,
	input  logic                                rd_en,
	input  logic [CAW-1:0]                      rd_addr,
	output logic [2*NW-1:0]                     rd_data,
	output logic [CW-1:0]                       total,
	output logic                                overflow
);

	logic [2*NW-1:0] mem [MAX_CLAUSES];
	logic [CW-1:0]   total_q;
	logic            overflow_q;
	logic [tsat_pkg::LIT_W-1:0] mag_a, mag_b;
	logic [tsat_pkg::LIT_W:0]   node_a, node_b;
	logic            ok_a, ok_b, full;

	always_comb begin
		mag_a  = lit_a[tsat_pkg::LIT_W-1] ? tsat_pkg::LIT_W'(-lit_a) : tsat_pkg::LIT_W'(lit_a);
		mag_b  = lit_b[tsat_pkg::LIT_W-1] ? tsat_pkg::LIT_W'(-lit_b) : tsat_pkg::LIT_W'(lit_b);
		ok_a   = (lit_a != '0) && (32'(mag_a) <= 32'(var_live));
		ok_b   = (lit_b != '0) && (32'(mag_b) <= 32'(var_live));
		// positive literal k maps to node 2k-1, negative to 2k-2
		node_a = {mag_a, 1'b0} - (lit_a[tsat_pkg::LIT_W-1] ? 13'd2 : 13'd1);
		node_b = {mag_b, 1'b0} - (lit_b[tsat_pkg::LIT_W-1] ? 13'd2 : 13'd1);
		full   = (32'(total_q) >= MAX_CLAUSES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			overflow_q <= 1'b0;
		end else if (clear) begin
			total_q    <= '0;
			overflow_q <= 1'b0;
		end else if (add_en && ok_a && ok_b) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_en && ok_a && ok_b && !full && !clear) begin
			mem[total_q[CAW-1:0]] <= {NW'(node_b), NW'(node_a)};
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign total    = total_q;
	assign overflow = overflow_q;

endmodule

// ===== hdl/two_sat_scc_solver_unit.sv =====
// Clause load: one transfer per cycle while idle, no result.
// Solve: clears 2n node entries, then walks the literal graph; each edge lookup scans the
// clause store; it then reads out the assignment and sends the result words, which stall
// under output back-pressure.
// Reset (arst_n low, asynchronous) empties the clause store, clears the overflow flag and
// sets var_count to 1; the node, stack and assignment memories are not cleared by reset.
module two_sat_scc_solver_unit #(
	parameter int MAX_VARS    = tsat_pkg::MAX_VARS_DEF,
	parameter int MAX_CLAUSES = tsat_pkg::MAX_CLAUSES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsat_pkg::CFG_W-1:0]        cfg_wdata,   // var_count
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tsat_pkg::S_TDATA_W-1:0]    s_tdata,     // first_literal, second_literal
	input  logic                              s_tuser,     // operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// satisfiable, word_index[3:0], assignment_word[63:0], clauses_dropped, zero pad
	output logic [tsat_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast      // last_word
);

	localparam int NODES = 2 * MAX_VARS;
	localparam int NW    = $clog2(NODES);
	localparam int CNTW  = $clog2(NODES + 1);
	localparam int VW    = $clog2(MAX_VARS + 1);
	localparam int CW    = $clog2(MAX_CLAUSES + 1);
	localparam int CAW   = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
	localparam int WORDS = (MAX_VARS + 63) / 64;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WCW   = $clog2(WORDS + 1);
	localparam int WW    = tsat_pkg::WORD_W;

	typedef struct packed {
		logic [CNTW-1:0] visit;
		logic            done;
		logic [NW-1:0]   comp;
	} nent_t;

	typedef struct packed {
		logic [NW-1:0]   node;
		logic [CW-1:0]   ci;
		logic            ph;
		logic [CNTW-1:0] low;
		logic [CNTW-1:0] vis;
	} frame_t;

	tsat_pkg::state_t state_q, state_d;

	logic [tsat_pkg::CFG_W-1:0] var_count_q;
	logic [VW-1:0]   n_live, n_q, ai_q;
	logic [CNTW-1:0] nn_q, idx_q, cnt_q, low_q, vis_q, depth_q, pend_q;
	logic [NW-1:0]   comp_q, u_q, t_q, negc_q;
	logic [CW-1:0]   ci_q;
	logic            ph_q, sat_q, drop_q;
	logic [WW-1:0]   aword_q, aword_nx;
	logic [WCW-1:0]  widx_q, words_q;

	// memories
	nent_t           node_mem  [NODES];
	frame_t          frame_mem [NODES];
	logic [NW-1:0]   pend_mem  [NODES];
	logic [WW-1:0]   asg_mem   [WORDS];
	nent_t           node_rd;
	frame_t          frame_rd;
	logic [NW-1:0]   pend_rd;
	logic [WW-1:0]   asg_rd;

	logic            node_we, node_re, frame_we, frame_re, pend_we, pend_re, asg_we, asg_re;
	logic [NW-1:0]   node_waddr, node_raddr, frame_waddr, frame_raddr, pend_waddr, pend_raddr;
	nent_t           node_wdata;
	frame_t          frame_wdata;
	logic [NW-1:0]   pend_wdata;
	logic [WAW-1:0]  asg_addr;

	logic            cl_re, cl_clear, cl_add, cl_over;
	logic [2*NW-1:0] cl_rd;
	logic [CW-1:0]   cl_total;
	logic [NW-1:0]   ea, eb, e_tgt;
	logic            e_ok, e_match, s_acc, solve_acc, word_end, a_bit, out_load, out_last;

	assign s_acc     = s_tvalid && s_tready;
	assign solve_acc = s_acc && (s_tuser == tsat_pkg::OP_SOLVE);

	always_comb begin
		n_live = (32'(var_count_q) > MAX_VARS) ? VW'(MAX_VARS) : VW'(var_count_q);
	end

	tsat_clause_store #(
		.MAX_VARS    (MAX_VARS),
		.MAX_CLAUSES (MAX_CLAUSES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.var_live (n_live),
		.add_en   (cl_add),
		.lit_a    (s_tdata[11:0]),
		.lit_b    (s_tdata[23:12]),
		.clear    (cl_clear),
		.rd_en    (cl_re),
		.rd_addr  (ci_q[CAW-1:0]),
		.rd_data  (cl_rd),
		.total    (cl_total),
		.overflow (cl_over)
	);

	assign cl_add   = s_acc && (s_tuser == tsat_pkg::OP_ADD);
	// empty the store once the last result word of the solve is loaded
	assign cl_clear = out_load && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= tsat_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			var_count_q <= cfg_wdata;
		end
	end

	// edge check on the clause just read: phase 0 is not-a -> b, phase 1 is not-b -> a
	always_comb begin
		ea       = cl_rd[NW-1:0];
		eb       = cl_rd[2*NW-1:NW];
		e_ok     = (CNTW'(ea) < nn_q) && (CNTW'(eb) < nn_q);
		e_match  = e_ok && (ph_q ? ((eb ^ NW'(1)) == u_q) : ((ea ^ NW'(1)) == u_q));
		e_tgt    = ph_q ? ea : eb;
		a_bit    = node_rd.comp < negc_q;
		aword_nx = aword_q | (WW'(a_bit) << ai_q[5:0]);
		word_end = (ai_q[5:0] == 6'd63) || (ai_q == n_q - 1'b1);
		out_load = (state_q == tsat_pkg::S_OLD) && (!m_tvalid || m_tready);
		out_last = (widx_q + 1'b1) == words_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		node_we     = 1'b0;
		node_re     = 1'b0;
		node_waddr  = idx_q[NW-1:0];
		node_raddr  = idx_q[NW-1:0];
		node_wdata  = '0;
		frame_we    = 1'b0;
		frame_re    = 1'b0;
		frame_waddr = NW'(depth_q - 1'b1);
		frame_raddr = NW'(depth_q - 2'd2);
		frame_wdata = '{node: u_q, ci: ci_q, ph: ph_q, low: low_q, vis: vis_q};
		pend_we     = 1'b0;
		pend_re     = 1'b0;
		pend_waddr  = NW'(pend_q);
		pend_raddr  = NW'(pend_q - 1'b1);
		pend_wdata  = idx_q[NW-1:0];
		asg_we      = 1'b0;
		asg_re      = 1'b0;
		asg_addr    = WAW'(ai_q >> 6);
		cl_re       = 1'b0;
		case (state_q)
			tsat_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == tsat_pkg::OP_SOLVE) begin
					state_d = (n_live == '0) ? tsat_pkg::S_ORD : tsat_pkg::S_CLR;
				end
			end
			tsat_pkg::S_CLR: begin
				node_we = 1'b1;
				if (idx_q == nn_q - 1'b1) state_d = tsat_pkg::S_ROOT;
			end
			tsat_pkg::S_ROOT: begin
				if (idx_q == nn_q) begin
					state_d = tsat_pkg::S_ANEG;
				end else begin
					node_re = 1'b1;
					state_d = tsat_pkg::S_ROOTCHK;
				end
			end
			tsat_pkg::S_ROOTCHK: begin
				if (node_rd.visit == '0) begin
					node_we    = 1'b1;
					node_wdata = '{visit: cnt_q + 1'b1, done: 1'b0, comp: '0};
					pend_we    = 1'b1;
					state_d    = tsat_pkg::S_SCAN;
				end else begin
					state_d = tsat_pkg::S_ROOT;
				end
			end
			tsat_pkg::S_SCAN: begin
				if (ci_q == cl_total) begin
					state_d = tsat_pkg::S_FIN;
				end else begin
					cl_re   = 1'b1;
					state_d = tsat_pkg::S_EDGE;
				end
			end
			tsat_pkg::S_EDGE: begin
				if (e_match) begin
					node_re    = 1'b1;
					node_raddr = e_tgt;
					state_d    = tsat_pkg::S_TGT;
				end else if (!ph_q) begin
					state_d = tsat_pkg::S_EDGE;
				end else begin
					state_d = tsat_pkg::S_SCAN;
				end
			end
			tsat_pkg::S_TGT: begin
				if (node_rd.visit == '0) begin
					frame_we   = 1'b1;
					node_we    = 1'b1;
					node_waddr = t_q;
					node_wdata = '{visit: cnt_q + 1'b1, done: 1'b0, comp: '0};
					pend_we    = 1'b1;
					pend_wdata = t_q;
				end
				state_d = tsat_pkg::S_SCAN;
			end
			tsat_pkg::S_FIN: begin
				state_d = (low_q == vis_q) ? tsat_pkg::S_POPR : tsat_pkg::S_RET;
			end
			tsat_pkg::S_POPR: begin
				pend_re = 1'b1;
				state_d = tsat_pkg::S_POPW;
			end
			tsat_pkg::S_POPW: begin
				// closed nodes keep a nonzero visit so they are never entered again
				node_we    = 1'b1;
				node_waddr = pend_rd;
				node_wdata = '{visit: CNTW'(1), done: 1'b1, comp: comp_q};
				state_d    = (pend_rd == u_q) ? tsat_pkg::S_RET : tsat_pkg::S_POPR;
			end
			tsat_pkg::S_RET: begin
				if (depth_q == CNTW'(1)) begin
					state_d = tsat_pkg::S_ROOT;
				end else begin
					frame_re = 1'b1;
					state_d  = tsat_pkg::S_RET2;
				end
			end
			tsat_pkg::S_RET2: begin
				state_d = tsat_pkg::S_SCAN;
			end
			tsat_pkg::S_ANEG: begin
				if (ai_q == n_q) begin
					state_d = tsat_pkg::S_ORD;
				end else begin
					node_re    = 1'b1;
					node_raddr = NW'({ai_q, 1'b0});
					state_d    = tsat_pkg::S_APOS;
				end
			end
			tsat_pkg::S_APOS: begin
				node_re    = 1'b1;
				node_raddr = NW'({ai_q, 1'b1});
				state_d    = tsat_pkg::S_ACMP;
			end
			tsat_pkg::S_ACMP: begin
				if (node_rd.comp == negc_q) begin
					state_d = tsat_pkg::S_ORD;
				end else begin
					asg_we  = word_end;
					state_d = tsat_pkg::S_ANEG;
				end
			end
			tsat_pkg::S_ORD: begin
				asg_re   = 1'b1;
				asg_addr = WAW'(widx_q);
				state_d  = tsat_pkg::S_OLD;
			end
			tsat_pkg::S_OLD: begin
				if (out_load) state_d = out_last ? tsat_pkg::S_IDLE : tsat_pkg::S_ORD;
			end
			default: state_d = tsat_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_waddr] <= node_wdata;
		if (node_re) node_rd <= node_mem[node_raddr];
		if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
		if (frame_re) frame_rd <= frame_mem[frame_raddr];
		if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
		if (pend_re) pend_rd <= pend_mem[pend_raddr];
		if (asg_we) asg_mem[asg_addr] <= aword_nx;
		if (asg_re) asg_rd <= asg_mem[asg_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			nn_q    <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			comp_q  <= '0;
			u_q     <= '0;
			t_q     <= '0;
			ci_q    <= '0;
			ph_q    <= 1'b0;
			low_q   <= '0;
			vis_q   <= '0;
			depth_q <= '0;
			pend_q  <= '0;
			ai_q    <= '0;
			negc_q  <= '0;
			aword_q <= '0;
			sat_q   <= 1'b0;
			drop_q  <= 1'b0;
			widx_q  <= '0;
			words_q <= '0;
		end else begin
			case (state_q)
				tsat_pkg::S_IDLE: begin
					if (solve_acc) begin
						n_q     <= n_live;
						nn_q    <= CNTW'({n_live, 1'b0});
						idx_q   <= '0;
						cnt_q   <= '0;
						comp_q  <= '0;
						pend_q  <= '0;
						depth_q <= '0;
						ai_q    <= '0;
						aword_q <= '0;
						sat_q   <= 1'b1;
						drop_q  <= cl_over;
						widx_q  <= '0;
						words_q <= (n_live == '0) ? WCW'(1) : WCW'((32'(n_live) + 32'd63) >> 6);
					end
				end
				tsat_pkg::S_CLR: begin
					idx_q <= (idx_q == nn_q - 1'b1) ? '0 : idx_q + 1'b1;
				end
				tsat_pkg::S_ROOTCHK: begin
					if (node_rd.visit == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						u_q     <= idx_q[NW-1:0];
						ci_q    <= '0;
						ph_q    <= 1'b0;
						low_q   <= cnt_q + 1'b1;
						vis_q   <= cnt_q + 1'b1;
						depth_q <= CNTW'(1);
						pend_q  <= pend_q + 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tsat_pkg::S_EDGE: begin
					t_q <= e_tgt;
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						ci_q <= ci_q + 1'b1;
					end
				end
				tsat_pkg::S_TGT: begin
					if (node_rd.visit == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						u_q     <= t_q;
						ci_q    <= '0;
						ph_q    <= 1'b0;
						low_q   <= cnt_q + 1'b1;
						vis_q   <= cnt_q + 1'b1;
						depth_q <= depth_q + 1'b1;
						pend_q  <= pend_q + 1'b1;
					end else if (!node_rd.done && node_rd.visit < low_q) begin
						low_q <= node_rd.visit;
					end
				end
				tsat_pkg::S_POPW: begin
					pend_q <= pend_q - 1'b1;
					if (pend_rd == u_q) comp_q <= comp_q + 1'b1;
				end
				tsat_pkg::S_RET: begin
					depth_q <= depth_q - 1'b1;
					if (depth_q == CNTW'(1)) idx_q <= idx_q + 1'b1;
				end
				tsat_pkg::S_RET2: begin
					u_q   <= frame_rd.node;
					ci_q  <= frame_rd.ci;
					ph_q  <= frame_rd.ph;
					vis_q <= frame_rd.vis;
					low_q <= (low_q < frame_rd.low) ? low_q : frame_rd.low;
				end
				tsat_pkg::S_APOS: begin
					negc_q <= node_rd.comp;
				end
				tsat_pkg::S_ACMP: begin
					if (node_rd.comp == negc_q) begin
						sat_q   <= 1'b0;
						words_q <= WCW'(1);
					end else begin
						aword_q <= word_end ? '0 : aword_nx;
						ai_q    <= ai_q + 1'b1;
					end
				end
				tsat_pkg::S_OLD: begin
					if (out_load) widx_q <= widx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata[0]     <= sat_q;
			m_tdata[4:1]   <= tsat_pkg::WIDX_W'(widx_q);
			m_tdata[68:5]  <= (sat_q && n_q != '0) ? asg_rd : '0;
			m_tdata[69]    <= drop_q;
			m_tdata[71:70] <= 2'b00;
			m_tlast        <= out_last;
		end
	end

endmodule

// ===== hdl/tsat_checker.sv =====
module tsat_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tsat_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_unsat_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tlast && (m_tdata[4:1] == 4'd0) && (m_tdata[68:5] == '0))
		else $error("unsatisfiable result is not a single empty word");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == tsat_pkg::OP_SOLVE) |=> !s_tready)
		else $error("input taken right after a solve transfer");

endmodule

bind two_sat_scc_solver_unit tsat_checker u_tsat_checker (.*);
